/* sv/mhf_pkg.sv */
// constants, codes and crc helper shared by the multicast hash filter
package mhf_pkg;

  // request codes
  localparam logic OP_IPV4 = 1'b0;
  localparam logic OP_IPV6 = 1'b1;

  // crc-32 settings
  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // group mac prefixes
  localparam logic [7:0] V4_OUI0     = 8'h01;
  localparam logic [7:0] V4_OUI1     = 8'h00;
  localparam logic [7:0] V4_OUI2     = 8'h5E;
  localparam logic [6:0] V4_LOW_MASK = 7'h7F;
  localparam logic [7:0] V6_PREFIX   = 8'h33;

  // field widths
  localparam int unsigned TAIL_W  = 32;
  localparam int unsigned MAC_W   = 48;
  localparam int unsigned HASH_W  = 6;
  localparam int unsigned TABLE_W = 64;
  localparam int unsigned HALF_W  = 32;

  // one byte through the crc register, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                           input logic [7:0] data);
    logic [31:0] crc;
    logic        fb;
    crc = crc_in;
    for (int b = 0; b < 8; b++) begin
      fb  = crc[31] ^ data[b];
      crc = {crc[30:0], 1'b0} ^ (fb ? CRC_POLY : 32'h0);
    end
    return crc;
  endfunction

endpackage

/* sv/mhf_mac.sv */
// forms the group mac address from a join request
module mhf_mac (
  input  logic                       opcode,
  input  logic [mhf_pkg::TAIL_W-1:0] group_tail,
  output logic [mhf_pkg::MAC_W-1:0]  group_mac
);

  // ipv6 maps 33:33 plus four octets, ipv4 maps 01:00:5e plus low 23 bits
  always_comb begin
    case (opcode)
      mhf_pkg::OP_IPV6: begin
        group_mac = {mhf_pkg::V6_PREFIX, mhf_pkg::V6_PREFIX, group_tail};
      end
      mhf_pkg::OP_IPV4: begin
        group_mac = {mhf_pkg::V4_OUI0, mhf_pkg::V4_OUI1, mhf_pkg::V4_OUI2,
                     1'b0, group_tail[22:16] & mhf_pkg::V4_LOW_MASK,
                     group_tail[15:0]};
      end
      default: begin
        group_mac = '0;
      end
    endcase
  end

endmodule

/* sv/mhf_crc.sv */
// crc-32 over the six mac bytes and hash bit selection
module mhf_crc (
  input  logic [mhf_pkg::MAC_W-1:0]  group_mac,
  output logic [mhf_pkg::HASH_W-1:0] hash_index
);

  logic [31:0] crc;

  // bytes go in first-transmitted first; the result is inverted
  always_comb begin
    crc = mhf_pkg::CRC_INIT;
    for (int n = 0; n < 6; n++) begin
      crc = mhf_pkg::crc_byte(crc, group_mac[mhf_pkg::MAC_W-1-8*n -: 8]);
    end
    hash_index = ~crc[31:26];
  end

endmodule

/* sv/multicast_hash_filter_update.sv */
// multicast hash filter: group mac, crc hash and 64-bit table update
//
//  channel | ports                                         | direction
//  in      | in_valid, in_ready, in_opcode, in_group_tail  | request word in
//  out     | out_valid, out_ready, out_group_mac,          | result word out
//          | out_hash_index, out_table_high, out_table_low |
//
// one word per cycle while out_ready is high; a taken request passes through the input register,
// then mac forming, crc and table update into the output register, which drives the outputs.
// rst_n clears the valid flags and the hash table, no clearing pass.
// when out_ready is low the output register holds and the input register fills,
// after which in_ready drops.
module multicast_hash_filter_update (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_opcode,
  input  logic [mhf_pkg::TAIL_W-1:0]  in_group_tail,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mhf_pkg::MAC_W-1:0]   out_group_mac,
  output logic [mhf_pkg::HASH_W-1:0]  out_hash_index,
  output logic [mhf_pkg::HALF_W-1:0]  out_table_high,
  output logic [mhf_pkg::HALF_W-1:0]  out_table_low
);

  logic                         s1_valid_r;
  logic                         s1_opcode_r;
  logic [mhf_pkg::TAIL_W-1:0]   s1_tail_r;
  logic                         s1_ready;
  logic                         s1_move;

  logic [mhf_pkg::MAC_W-1:0]    mac;
  logic [mhf_pkg::HASH_W-1:0]   hash_index;

  logic [mhf_pkg::TABLE_W-1:0]  table_r;
  logic [mhf_pkg::TABLE_W-1:0]  table_nxt;

  logic                         out_valid_r;
  logic [mhf_pkg::MAC_W-1:0]    out_mac_r;
  logic [mhf_pkg::HASH_W-1:0]   out_index_r;
  logic [mhf_pkg::TABLE_W-1:0]  out_table_r;

  // handshake between the two registers
  assign s1_ready = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && s1_ready;
  assign in_ready = !s1_valid_r || s1_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_opcode_r <= in_opcode;
      s1_tail_r   <= in_group_tail;
    end
  end

  mhf_mac u_mac (
    .opcode     (s1_opcode_r),
    .group_tail (s1_tail_r),
    .group_mac  (mac)
  );

  mhf_crc u_crc (
    .group_mac  (mac),
    .hash_index (hash_index)
  );

  // set the selected table bit
  assign table_nxt = table_r | (mhf_pkg::TABLE_W'(1) << hash_index);

  // hash table and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        table_r <= table_nxt;
      end
    end
    if (s1_move) begin
      out_mac_r   <= mac;
      out_index_r <= hash_index;
      out_table_r <= table_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_group_mac  = out_mac_r;
  assign out_hash_index = out_index_r;
  assign out_table_high = out_table_r[mhf_pkg::TABLE_W-1:mhf_pkg::HALF_W];
  assign out_table_low  = out_table_r[mhf_pkg::HALF_W-1:0];

`ifndef SYNTHESIS
  // table bits are only ever set
  a_table_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((table_r & $past(table_r)) == $past(table_r)))
    else $error("hash table bit cleared");

  // a shown result has its own hash bit set
  a_index_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_table_r[out_index_r])
    else $error("result table lacks its hash bit");

  // a stalled input word is kept
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_ready) |=> (s1_valid_r && $stable(s1_tail_r)))
    else $error("stalled input word lost");
`endif

endmodule

/* tb/multicast_hash_filter_update_tb.sv */
// self-checking testbench for the multicast hash filter update block
`timescale 1ns / 100ps

module multicast_hash_filter_update_tb;

  localparam int unsigned STALL_LIMIT = 400;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [mhf_pkg::MAC_W-1:0]  mac;
    logic [mhf_pkg::HASH_W-1:0] index;
    logic [mhf_pkg::HALF_W-1:0] high;
    logic [mhf_pkg::HALF_W-1:0] low;
  } join_result_t;

  logic                         clk;
  logic                         rst_n;
  logic                         in_valid;
  logic                         in_ready;
  logic                         in_opcode;
  logic [mhf_pkg::TAIL_W-1:0]   in_group_tail;
  logic                         out_valid;
  logic                         out_ready;
  logic [mhf_pkg::MAC_W-1:0]    out_group_mac;
  logic [mhf_pkg::HASH_W-1:0]   out_hash_index;
  logic [mhf_pkg::HALF_W-1:0]   out_table_high;
  logic [mhf_pkg::HALF_W-1:0]   out_table_low;

  // predictor state and pending results
  logic [mhf_pkg::TABLE_W-1:0]  filter_table;
  join_result_t                 pending_joins[$];
  logic [mhf_pkg::TAIL_W-1:0]   recent_tails[$];
  int unsigned                  error_count;
  int unsigned                  quiet_cycles;
  bit                           send_idle_en;
  bit                           recv_idle_en;

  multicast_hash_filter_update u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_group_tail  (in_group_tail),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_group_mac  (out_group_mac),
    .out_hash_index (out_hash_index),
    .out_table_high (out_table_high),
    .out_table_low  (out_table_low)
  );

  // 20 ns clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // group mac from the request
  function automatic logic [mhf_pkg::MAC_W-1:0] group_mac_of(
      input logic op, input logic [mhf_pkg::TAIL_W-1:0] tail);
    if (op == mhf_pkg::OP_IPV6)
      return {mhf_pkg::V6_PREFIX, mhf_pkg::V6_PREFIX, tail};
    return {mhf_pkg::V4_OUI0, mhf_pkg::V4_OUI1, mhf_pkg::V4_OUI2, 1'b0,
            tail[22:0] & {mhf_pkg::V4_LOW_MASK, 16'hFFFF}};
  endfunction

  // crc-32 over the mac bits in wire order, top six bits of the inverted value
  function automatic logic [mhf_pkg::HASH_W-1:0] hash_index_of(
      input logic [mhf_pkg::MAC_W-1:0] mac);
    logic [31:0] sum;
    logic        din;
    sum = mhf_pkg::CRC_INIT;
    for (int n = 0; n < 6; n++)
      for (int b = 0; b < 8; b++) begin
        din = mac[mhf_pkg::MAC_W - 8 - 8 * n + b];
        if (sum[31] ^ din)
          sum = (sum << 1) ^ mhf_pkg::CRC_POLY;
        else
          sum = sum << 1;
      end
    sum = ~sum;
    return sum[31:26];
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // one request word: drive at the falling edge, hold until taken
  task automatic send_join(input logic op, input logic [mhf_pkg::TAIL_W-1:0] tail);
    join_result_t res;
    @(negedge clk);
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_group_tail <= tail;
    do @(posedge clk); while (!in_ready);
    res.mac       = group_mac_of(op, tail);
    res.index     = hash_index_of(res.mac);
    filter_table  = filter_table | (64'd1 << res.index);
    res.high      = filter_table[63:32];
    res.low       = filter_table[31:0];
    pending_joins.push_back(res);
    recent_tails.push_back(tail);
    if (recent_tails.size() > 16)
      void'(recent_tails.pop_front());
  endtask

  // sender idle burst, only when enabled
  task automatic sender_pause();
    int unsigned gap;
    if (send_idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 19);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic test_ipv4_extremes();
    send_join(mhf_pkg::OP_IPV4, 32'h0000_0000);
    send_join(mhf_pkg::OP_IPV4, 32'hFFFF_FFFF);
    send_join(mhf_pkg::OP_IPV4, 32'h007F_FFFF);
    send_join(mhf_pkg::OP_IPV4, 32'hFF80_0000);   // only ignored bits set
    send_join(mhf_pkg::OP_IPV4, 32'h0080_0000);   // bit 23 alone is dropped
    send_join(mhf_pkg::OP_IPV4, 32'hAAAA_AAAA);
    send_join(mhf_pkg::OP_IPV4, 32'h5555_5555);
    send_join(mhf_pkg::OP_IPV4, 32'hE000_0001);
  endtask

  task automatic test_ipv6_extremes();
    send_join(mhf_pkg::OP_IPV6, 32'h0000_0000);
    send_join(mhf_pkg::OP_IPV6, 32'hFFFF_FFFF);
    send_join(mhf_pkg::OP_IPV6, 32'h8000_0000);
    send_join(mhf_pkg::OP_IPV6, 32'h0000_0001);
    send_join(mhf_pkg::OP_IPV6, 32'hAAAA_AAAA);
    send_join(mhf_pkg::OP_IPV6, 32'h5555_5555);
    send_join(mhf_pkg::OP_IPV6, 32'hFF00_00FB);
  endtask

  // repeated groups and aliased ipv4 groups both set an already set bit
  task automatic test_repeated_group();
    send_join(mhf_pkg::OP_IPV6, 32'h0000_0001);
    send_join(mhf_pkg::OP_IPV6, 32'h0000_0001);
    send_join(mhf_pkg::OP_IPV4, 32'h0000_0000);
    send_join(mhf_pkg::OP_IPV4, 32'hFF80_0000);
    send_join(mhf_pkg::OP_IPV6, 32'h1234_5678);
    send_join(mhf_pkg::OP_IPV6, 32'h1234_5678);
  endtask

  // random groups in blocks, idling on in some blocks and off in others
  task automatic test_random_traffic();
    logic [mhf_pkg::TAIL_W-1:0] tail;
    int unsigned                pick;
    for (int blk = 0; blk < 12; blk++) begin
      send_idle_en = (blk % 3 != 2);
      recv_idle_en = (blk % 4 != 3);
      for (int i = 0; i < 100; i++) begin
        pick = $urandom_range(0, 9);
        if (pick < 2 && recent_tails.size() > 0)
          tail = recent_tails[$urandom_range(0, recent_tails.size() - 1)];
        else if (pick == 2)
          tail = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        else
          tail = $urandom;
        send_join($urandom_range(0, 1) ? mhf_pkg::OP_IPV6 : mhf_pkg::OP_IPV4, tail);
        sender_pause();
      end
    end
  endtask

  // closing stretch at full rate, no idling on either side
  task automatic test_back_to_back();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    for (int i = 0; i < 200; i++)
      send_join($urandom_range(0, 1) ? mhf_pkg::OP_IPV6 : mhf_pkg::OP_IPV4, $urandom);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // receiver stall bursts
  initial begin
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (recv_idle_en && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  // result check against the oldest pending join
  always @(posedge clk) begin
    join_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_joins.size() == 0) begin
        report_mismatch("unexpected result word", {16'h0, out_group_mac}, 64'h0);
      end else begin
        want = pending_joins.pop_front();
        if (out_group_mac !== want.mac)
          report_mismatch("group_mac", {16'h0, out_group_mac}, {16'h0, want.mac});
        if (out_hash_index !== want.index)
          report_mismatch("hash_index", {58'h0, out_hash_index}, {58'h0, want.index});
        if (out_table_high !== want.high)
          report_mismatch("table_high", {32'h0, out_table_high}, {32'h0, want.high});
        if (out_table_low !== want.low)
          report_mismatch("table_low", {32'h0, out_table_low}, {32'h0, want.low});
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_opcode     = mhf_pkg::OP_IPV4;
    in_group_tail = '0;
    filter_table  = '0;
    error_count   = 0;
    quiet_cycles  = 0;
    send_idle_en  = 1'b1;
    recv_idle_en  = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_ipv4_extremes();
    test_ipv6_extremes();
    test_repeated_group();
    test_random_traffic();
    test_back_to_back();

    // drain, then allow the pipeline to settle
    while (pending_joins.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_joins.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
